// ===== src/bpqm_pkg.sv =====
`default_nettype none

package bpqm_pkg;

   localparam int NUM_BLOCKS = 64;
   localparam int NUM_QUEUES = 4;
   localparam int LIMIT_REGS = 4;

   localparam int BLK_W      = $clog2(NUM_BLOCKS);
   localparam int LINK_W     = $clog2(NUM_BLOCKS + 1);
   localparam int CNT_W      = LINK_W;
   localparam int LIMIT_W    = 7;
   localparam int QID_W      = 2;
   localparam int ACT_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int BSTAT_W    = 2;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = LIMIT_W;

   // the index one past the last block marks an empty link
   localparam logic [LINK_W-1:0]  NIL_LINK    = LINK_W'(NUM_BLOCKS);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

   typedef enum logic [ACT_W-1:0] {
      ACT_ALLOC    = 3'd0,
      ACT_FREE     = 3'd1,
      ACT_ENQ_HEAD = 3'd2,
      ACT_ENQ_TAIL = 3'd3,
      ACT_DEQUEUE  = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK       = 2'd0,
      STS_EMPTY    = 2'd1,
      STS_NOT_HELD = 2'd2,
      STS_FULL     = 2'd3
   } status_type;

   typedef enum logic [BSTAT_W-1:0] {
      BS_FREE   = 2'd0,
      BS_HELD   = 2'd1,
      BS_QUEUED = 2'd2
   } bstat_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef logic [LIMIT_REGS-1:0][LIMIT_W-1:0] limit_array_type;

   typedef struct packed {
      logic             en;
      logic [BLK_W-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic              en;
      logic [BLK_W-1:0]  addr;
      logic [LINK_W-1:0] data;
   } link_wr_type;

   typedef struct packed {
      logic             en;
      logic [BLK_W-1:0] addr;
      bstat_type        data;
   } stat_wr_type;

endpackage

`default_nettype wire

// ===== src/bpqm_ram.sv =====
`default_nettype none

module bpqm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/bpqm_engine.sv =====
`default_nettype none

module bpqm_engine import bpqm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [2:0] action, [4:3] queue_id, [10:5] block_index, [15:11] unused
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [1:0] status, [7:2] result_block, [14:8] queue_fill, [15] zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   input  wire limit_array_type       queue_limit,
   output mem_rd_type                 mem_rd,
   input  wire logic [LINK_W-1:0]     link_rd_data,
   input  wire bstat_type             stat_rd_data,
   output link_wr_type                link_wr,
   output stat_wr_type                stat_wr
);

   typedef struct packed {
      action_type       action;
      logic [QID_W-1:0] qid;
      logic [BLK_W-1:0] blk;
      logic             rd_ok;
      logic [BLK_W-1:0] rd_addr;
   } cmd_type;

   typedef logic [NUM_QUEUES-1:0][LINK_W-1:0] qlink_array_type;
   typedef logic [NUM_QUEUES-1:0][CNT_W-1:0]  qcount_array_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [LINK_W-1:0] free_head_ff, free_head_in;
   // blocks at or above this mark have never been allocated
   logic [LINK_W-1:0] fill_ff, fill_in;
   qlink_array_type  q_head_ff, q_head_in;
   qlink_array_type  q_tail_ff, q_tail_in;
   qcount_array_type q_count_ff, q_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   action_type        req_action;
   logic [QID_W-1:0]  req_qid;
   logic [BLK_W-1:0]  req_blk;
   logic              req_qok;
   logic              req_accept;
   logic [LINK_W-1:0] rd_link;

   logic              out_free;
   logic              exec_go;
   logic              fresh;
   logic [LINK_W-1:0] eff_link;
   bstat_type         eff_stat;
   logic              qok;
   logic [CNT_W-1:0]  cur_count, new_count;
   logic [LINK_W-1:0] cur_head, cur_tail, head_new, tail_new;
   logic [LIMIT_W-1:0] cur_limit;
   status_type        sts;
   logic [BLK_W-1:0]  res;
   logic [CNT_W-1:0]  fill_out;

   // request decode and read address
   always_comb begin
      req_action = action_type'(req_tdata[ACT_W-1:0]);
      req_qid    = req_tdata[ACT_W +: QID_W];
      req_blk    = req_tdata[ACT_W+QID_W +: BLK_W];
      req_qok    = int'(req_qid) < NUM_QUEUES;
      req_accept = req_tvalid && req_tready;
   end

   always_comb begin
      case (req_action)
         ACT_ALLOC:   rd_link = free_head_ff;
         ACT_DEQUEUE: rd_link = req_qok ? q_tail_ff[req_qid] : NIL_LINK;
         default:     rd_link = LINK_W'(req_blk);
      endcase
   end

   always_comb begin
      mem_rd.en   = req_accept;
      mem_rd.addr = rd_link[BLK_W-1:0];
      if (req_accept) begin
         cmd_in = '{action: req_action, qid: req_qid, blk: req_blk,
                    rd_ok: (rd_link < LINK_W'(NUM_BLOCKS)),
                    rd_addr: rd_link[BLK_W-1:0]};
      end else begin
         cmd_in = cmd_ff;
      end
   end

   // sequencer
   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = req_tvalid ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = out_free ? ST_IDLE : ST_EXEC;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            exec_go    = 1'b0;
         end
         ST_EXEC: begin
            req_tready = 1'b0;
            exec_go    = out_free;
         end
         default: begin
            req_tready = 1'b0;
            exec_go    = 1'b0;
         end
      endcase
   end

   // blocks never allocated read as free, each linked to the next block
   always_comb begin
      fresh     = LINK_W'(cmd_ff.rd_addr) >= fill_ff;
      eff_link  = fresh ? (LINK_W'(cmd_ff.rd_addr) + LINK_W'(1)) : link_rd_data;
      eff_stat  = fresh ? BS_FREE : stat_rd_data;
      qok       = int'(cmd_ff.qid) < NUM_QUEUES;
      cur_count = q_count_ff[cmd_ff.qid];
      cur_head  = q_head_ff[cmd_ff.qid];
      cur_tail  = q_tail_ff[cmd_ff.qid];
      cur_limit = queue_limit[cmd_ff.qid];
   end

   // read-modify-write of the link and status memories
   always_comb begin
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      q_head_in    = q_head_ff;
      q_tail_in    = q_tail_ff;
      q_count_in   = q_count_ff;
      head_new     = cur_head;
      tail_new     = cur_tail;
      new_count    = cur_count;
      sts          = STS_OK;
      res          = '0;
      link_wr      = '0;
      stat_wr      = '{en: 1'b0, addr: '0, data: BS_FREE};
      if (exec_go) begin
         case (cmd_ff.action)
            ACT_ALLOC: begin
               if (!cmd_ff.rd_ok) begin
                  sts = STS_EMPTY;
               end else begin
                  free_head_in = eff_link;
                  stat_wr = '{en: 1'b1, addr: cmd_ff.rd_addr, data: BS_HELD};
                  if (fresh) begin
                     fill_in = fill_ff + LINK_W'(1);
                  end
                  res = cmd_ff.rd_addr;
               end
            end
            ACT_FREE: begin
               if (eff_stat != BS_HELD) begin
                  sts = STS_NOT_HELD;
               end else begin
                  link_wr = '{en: 1'b1, addr: cmd_ff.blk, data: free_head_ff};
                  stat_wr = '{en: 1'b1, addr: cmd_ff.blk, data: BS_FREE};
                  free_head_in = LINK_W'(cmd_ff.blk);
               end
            end
            ACT_ENQ_HEAD, ACT_ENQ_TAIL: begin
               if (!qok || cur_count >= CNT_W'(cur_limit)) begin
                  sts = STS_FULL;
               end else if (eff_stat != BS_HELD) begin
                  sts = STS_NOT_HELD;
               end else begin
                  stat_wr   = '{en: 1'b1, addr: cmd_ff.blk, data: BS_QUEUED};
                  new_count = cur_count + CNT_W'(1);
                  if (cmd_ff.action == ACT_ENQ_HEAD) begin
                     // the old head learns its new neighbour towards the head
                     if (cur_head < LINK_W'(NUM_BLOCKS)) begin
                        link_wr = '{en: 1'b1, addr: cur_head[BLK_W-1:0],
                                    data: LINK_W'(cmd_ff.blk)};
                     end
                     head_new = LINK_W'(cmd_ff.blk);
                     if (cur_count == '0) begin
                        tail_new = LINK_W'(cmd_ff.blk);
                     end
                  end else begin
                     link_wr  = '{en: 1'b1, addr: cmd_ff.blk, data: cur_tail};
                     tail_new = LINK_W'(cmd_ff.blk);
                     if (cur_count == '0) begin
                        head_new = LINK_W'(cmd_ff.blk);
                     end
                  end
               end
            end
            ACT_DEQUEUE: begin
               if (!qok || cur_count == '0 || !cmd_ff.rd_ok) begin
                  sts = STS_EMPTY;
               end else begin
                  new_count = cur_count - CNT_W'(1);
                  tail_new  = eff_link;
                  if (new_count == '0) begin
                     head_new = NIL_LINK;
                     tail_new = NIL_LINK;
                  end
                  stat_wr = '{en: 1'b1, addr: cmd_ff.rd_addr, data: BS_HELD};
                  res     = cmd_ff.rd_addr;
               end
            end
            default: begin
               sts = STS_OK;
            end
         endcase
         if (qok) begin
            q_head_in[cmd_ff.qid]  = head_new;
            q_tail_in[cmd_ff.qid]  = tail_new;
            q_count_in[cmd_ff.qid] = new_count;
         end
      end
   end

   // result register
   always_comb begin
      fill_out = qok ? new_count : '0;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({fill_out, res, sts});
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= '0;
         fill_ff      <= '0;
         q_head_ff    <= {NUM_QUEUES{NIL_LINK}};
         q_tail_ff    <= {NUM_QUEUES{NIL_LINK}};
         q_count_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         q_head_ff    <= q_head_in;
         q_tail_ff    <= q_tail_in;
         q_count_ff   <= q_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LINK_W'(NUM_BLOCKS))
      else $error("fill mark beyond the pool");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while one is in work");

   a_wr_on_done: assert property (@(posedge clock) disable iff (reset)
      (link_wr.en || stat_wr.en) |-> (state_ff == ST_EXEC && out_free))
      else $error("memory write outside completion");

   a_link_pair: assert property (@(posedge clock) disable iff (reset)
      link_wr.en |-> stat_wr.en)
      else $error("link write without status change");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("result raised without an item in work");

endmodule

`default_nettype wire

// ===== src/block_pool_queue_manager.sv =====
// Flow: taking an item on req_ registers it and starts registered reads of the link and
// status memories; at completion the memories are written and the result is registered
// onto rsp_. No new item is taken until the current one completes (req_tready low).
// A result held on rsp_ by a low rsp_tready stalls completion of the following item.
// Reset: queues empty, free list holds blocks 0 upwards in order, limits read 10; memories
// are not cleared, a fill mark makes blocks never allocated read as free.
`default_nettype none

module block_pool_queue_manager import bpqm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [2:0] action, [4:3] queue_id, [10:5] block_index, [15:11] unused
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [1:0] status, [7:2] result_block, [14:8] queue_fill, [15] zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   limit_array_type limit_ff, limit_in;
   mem_rd_type      mem_rd;
   link_wr_type     link_wr;
   stat_wr_type     stat_wr;
   logic [LINK_W-1:0]  link_rd_data;
   logic [BSTAT_W-1:0] stat_rd_raw;

   always_comb begin
      limit_in = limit_ff;
      for (int i = 0; i < LIMIT_REGS; i++) begin
         if (csr_we && csr_index == CSR_IDX_W'(i)) begin
            limit_in[i] = csr_wdata[LIMIT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= {LIMIT_REGS{LIMIT_RESET}};
      end else begin
         limit_ff <= limit_in;
      end
   end

   // free blocks keep their successor on the free list, queued blocks the
   // neighbour towards the queue head
   bpqm_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BLOCKS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr.en),
      .wr_addr (link_wr.addr),
      .wr_data (link_wr.data),
      .rd_en   (mem_rd.en),
      .rd_addr (mem_rd.addr),
      .rd_data (link_rd_data)
   );

   bpqm_ram #(.WIDTH(BSTAT_W), .DEPTH(NUM_BLOCKS)) u_stat_ram (
      .clock   (clock),
      .wr_en   (stat_wr.en),
      .wr_addr (stat_wr.addr),
      .wr_data (BSTAT_W'(stat_wr.data)),
      .rd_en   (mem_rd.en),
      .rd_addr (mem_rd.addr),
      .rd_data (stat_rd_raw)
   );

   bpqm_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .queue_limit  (limit_ff),
      .mem_rd       (mem_rd),
      .link_rd_data (link_rd_data),
      .stat_rd_data (bstat_type'(stat_rd_raw)),
      .link_wr      (link_wr),
      .stat_wr      (stat_wr)
   );

endmodule

`default_nettype wire
